// ----- rtl/pcxrle_pkg.sv -----
package pcxrle_pkg;

  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] RunMark = 8'hc0;
  localparam logic [7:0] RunMask = 8'h3f;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegStride = 2'd2;

  typedef enum logic [2:0] {
    STATUS_PIXEL      = 3'd0,
    STATUS_ZERO_RUN   = 3'd1,
    STATUS_DATA_ENDED = 3'd2,
    STATUS_RUN_CUT    = 3'd3,
    STATUS_OVERRUN    = 3'd4,
    STATUS_BAD_STRIDE = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pixel;
    logic [15:0] column;
    logic [15:0] line;
    logic        run_end;
    logic        image_done;
  } out_res_t;

  typedef struct packed {
    logic [16:0] width;
    logic [16:0] height;
    logic [15:0] stride;
  } geom_t;

  typedef struct packed {
    logic        is_err;
    logic [2:0]  status;
    logic [7:0]  value;
    logic [5:0]  count;
    logic [15:0] column;
    logic [15:0] line;
  } cmd_t;

endpackage

// ----- rtl/pcx_rle_line_decoder_core.sv -----
// Run-length decoder for the pixel data of an 8-bit single-plane PCX image. Encoded bytes
// enter one per request; each yields no result (run header, padding, stopped), one
// result (literal pixel or error) or up to 63 pixel results, each with its column and
// line. The front sequencer takes a run header through idle and decode states, and a
// literal or run value byte through decode, multiply, compare, push into a short queue
// (held while it is full) and wrap, which steps once per line boundary the run crosses.
// The back expands it at one decoded byte per cycle, padding included, while the output
// is not stalled. Errors are sticky until a byte marked first_byte. Sizes are written by
// the user through the APB port at 0x0 (width), 0x4 (height) and 0x8 (stride) only while
// the block is idle, which it does not enforce; a width or height of zero counts as one.
module pcx_rle_line_decoder_core import pcxrle_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_res_t             out_data_o
);

  logic [16:0] width_q;
  logic [16:0] height_q;
  logic [15:0] stride_q;
  logic        wr_en;
  geom_t       geom;
  logic        push;
  logic        full;
  logic        pop;
  logic        q_valid;
  cmd_t        cmd_in;
  cmd_t        cmd_out;

  function automatic logic [16:0] clamp_size(input logic [16:0] v);
    logic [16:0] r;
    r = v;
    if (v == 17'd0) begin
      r = 17'd1;
    end else if (v > 17'h10000) begin
      r = 17'h10000;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 17'd1;
      height_q <= 17'd1;
      stride_q <= 16'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegWidth:  width_q  <= pwdata[16:0];
        RegHeight: height_q <= pwdata[16:0];
        RegStride: stride_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegWidth:  prdata = {15'b0, width_q};
      RegHeight: prdata = {15'b0, height_q};
      RegStride: prdata = {16'b0, stride_q};
      default:   prdata = '0;
    endcase
  end

  assign geom.width  = clamp_size(width_q);
  assign geom.height = clamp_size(height_q);
  assign geom.stride = stride_q;

  pcxrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full)
  );

  pcxrle_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  pcxrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .valid_i     (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/pcxrle_front.sv -----
module pcxrle_front import pcxrle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  geom_t   geom_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_req_t in_data_i,
  output logic    push_o,
  output cmd_t    cmd_o,
  input  logic    full_i
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StCmp    = 3'd3;
  localparam logic [2:0] StPush   = 3'd4;
  localparam logic [2:0] StWrap   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [7:0]  byte_q, byte_d;
  logic        final_q, final_d;
  logic        awaiting_q, awaiting_d;
  logic [5:0]  pending_q, pending_d;
  logic        stopped_q, stopped_d;
  logic [15:0] col_q, col_d;
  logic [15:0] line_q, line_d;
  logic [5:0]  count_q, count_d;
  logic [31:0] prod_q, prod_d;
  logic [15:0] tail_q, tail_d;
  logic        inrange_q, inrange_d;
  logic [16:0] tmp_q, tmp_d;
  cmd_t        cmd_q, cmd_d;

  logic [7:0]  hdr;
  logic [16:0] lines_left;
  logic [31:0] remaining;
  logic [31:0] count_ext;
  logic [16:0] stride_ext;

  assign hdr        = byte_q & RunMask;
  assign stride_ext = {1'b0, geom_i.stride};
  assign lines_left = geom_i.height - 17'd1 - {1'b0, line_q};
  assign remaining  = inrange_q ? (prod_q + {16'b0, tail_q}) : 32'd0;
  assign count_ext  = {26'b0, count_q};

  assign in_ready_o = (state_q == StIdle);
  assign push_o     = (state_q == StPush) && !full_i;
  assign cmd_o      = cmd_q;

  always_comb begin
    state_d    = state_q;
    byte_d     = byte_q;
    final_d    = final_q;
    awaiting_d = awaiting_q;
    pending_d  = pending_q;
    stopped_d  = stopped_q;
    col_d      = col_q;
    line_d     = line_q;
    count_d    = count_q;
    prod_d     = prod_q;
    tail_d     = tail_q;
    inrange_d  = inrange_q;
    tmp_d      = tmp_q;
    cmd_d      = cmd_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          byte_d  = in_data_i.data_byte;
          final_d = in_data_i.final_byte;
          if (in_data_i.first_byte) begin
            awaiting_d = 1'b0;
            pending_d  = '0;
            col_d      = '0;
            line_d     = '0;
            stopped_d  = 1'b0;
          end
          state_d = StDecode;
        end
      end
      StDecode: begin
        cmd_d        = '0;
        cmd_d.is_err = 1'b1;
        if (stopped_q) begin
          state_d = StIdle;
        end else if (stride_ext < geom_i.width) begin
          cmd_d.status = STATUS_BAD_STRIDE;
          stopped_d    = 1'b1;
          awaiting_d   = 1'b0;
          pending_d    = '0;
          state_d      = StPush;
        end else if (awaiting_q) begin
          count_d    = pending_q;
          awaiting_d = 1'b0;
          pending_d  = '0;
          state_d    = StMul;
        end else if ((byte_q & RunMark) == RunMark) begin
          if (hdr[5:0] == 6'd0) begin
            cmd_d.status = STATUS_ZERO_RUN;
            stopped_d    = 1'b1;
            state_d      = StPush;
          end else if (final_q) begin
            cmd_d.status = STATUS_RUN_CUT;
            stopped_d    = 1'b1;
            state_d      = StPush;
          end else begin
            awaiting_d = 1'b1;
            pending_d  = hdr[5:0];
            state_d    = StIdle;
          end
        end else begin
          count_d = 6'd1;
          state_d = StMul;
        end
      end
      StMul: begin
        inrange_d = ({1'b0, line_q} < geom_i.height) && (col_q < geom_i.stride);
        prod_d    = {16'b0, lines_left[15:0]} * {16'b0, geom_i.stride};
        tail_d    = geom_i.stride - col_q;
        state_d   = StCmp;
      end
      StCmp: begin
        cmd_d        = '0;
        cmd_d.is_err = 1'b1;
        state_d      = StPush;
        if (count_ext > remaining) begin
          cmd_d.status = STATUS_OVERRUN;
          stopped_d    = 1'b1;
        end else if (final_q && (count_ext != remaining)) begin
          cmd_d.status = STATUS_DATA_ENDED;
          stopped_d    = 1'b1;
        end else begin
          cmd_d.is_err = 1'b0;
          cmd_d.status = STATUS_PIXEL;
          cmd_d.value  = byte_q;
          cmd_d.count  = count_q;
          cmd_d.column = col_q;
          cmd_d.line   = line_q;
          tmp_d        = {1'b0, col_q} + {11'b0, count_q};
          if (count_ext == remaining) begin
            stopped_d = 1'b1;
          end
        end
      end
      StPush: begin
        if (!full_i) begin
          state_d = cmd_q.is_err ? StIdle : StWrap;
        end
      end
      StWrap: begin
        if (tmp_q >= stride_ext) begin
          tmp_d  = tmp_q - stride_ext;
          line_d = line_q + 16'd1;
        end else begin
          col_d   = tmp_q[15:0];
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      awaiting_q <= 1'b0;
      pending_q  <= '0;
      stopped_q  <= 1'b0;
      col_q      <= '0;
      line_q     <= '0;
    end else begin
      state_q    <= state_d;
      awaiting_q <= awaiting_d;
      pending_q  <= pending_d;
      stopped_q  <= stopped_d;
      col_q      <= col_d;
      line_q     <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    final_q   <= final_d;
    count_q   <= count_d;
    prod_q    <= prod_d;
    tail_q    <= tail_d;
    inrange_q <= inrange_d;
    tmp_q     <= tmp_d;
    cmd_q     <= cmd_d;
  end

  a_stop_clears_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stopped_q && state_q != StIdle) |-> !awaiting_q)
    else $error("header still pending after stop");

  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrap && tmp_q < {1'b0, geom_i.stride}) |=> (col_q < geom_i.stride))
    else $error("column left outside the stride");

endmodule

// ----- rtl/pcxrle_queue.sv -----
module pcxrle_queue import pcxrle_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  cmd_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("request popped from empty queue");

endmodule

// ----- rtl/pcxrle_back.sv -----
module pcxrle_back import pcxrle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  geom_t    geom_i,
  input  logic     valid_i,
  input  cmd_t     cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_data_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic        state_q, state_d;
  logic [7:0]  value_q, value_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] col_q, col_d;
  logic [15:0] line_q, line_d;
  logic        out_valid_q, out_valid_d;
  out_res_t    out_q, out_d;

  logic        slot_free;
  logic        emit;
  logic        step;
  logic        last_col;
  logic [5:0]  left;
  logic [16:0] col_next;
  logic [16:0] col_ahead;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = ({1'b0, col_q} < geom_i.width);
  assign step      = (state_q == StRun) && (!emit || slot_free);
  assign last_col  = ({1'b0, col_q} == (geom_i.width - 17'd1));
  assign left      = cnt_q - 6'd1;
  assign col_next  = {1'b0, col_q} + 17'd1;
  assign col_ahead = {1'b0, col_q} + {11'b0, left};
  assign pop_o     = (state_q == StIdle) && valid_i && (!cmd_i.is_err || slot_free);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    line_d      = line_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      if (cmd_i.is_err) begin
        out_d         = '0;
        out_d.status  = cmd_i.status;
        out_d.run_end = 1'b1;
        out_valid_d   = 1'b1;
      end else begin
        value_d = cmd_i.value;
        cnt_d   = cmd_i.count;
        col_d   = cmd_i.column;
        line_d  = cmd_i.line;
        state_d = StRun;
      end
    end
    if (step) begin
      if (emit) begin
        out_d.status     = STATUS_PIXEL;
        out_d.pixel      = value_q;
        out_d.column     = col_q;
        out_d.line       = line_q;
        out_d.run_end    = (left == 6'd0) ||
                           (last_col && (col_ahead < {1'b0, geom_i.stride}));
        out_d.image_done = last_col && ({1'b0, line_q} == (geom_i.height - 17'd1));
        out_valid_d      = 1'b1;
      end
      if (col_next >= {1'b0, geom_i.stride}) begin
        col_d  = '0;
        line_d = line_q + 16'd1;
      end else begin
        col_d = col_next[15:0];
      end
      cnt_d = left;
      if (cnt_q == 6'd1) begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    cnt_q   <= cnt_d;
    col_q   <= col_d;
    line_q  <= line_d;
    out_q   <= out_d;
  end

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (cnt_q != 6'd0))
    else $error("run active with no bytes left");

  a_pixel_in_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STATUS_PIXEL) |-> ({1'b0, out_q.column} < geom_i.width))
    else $error("pixel emitted in line padding");

endmodule

// ----- tb/sv/pcx_rle_line_decoder_core_test.sv -----
`timescale 1ns / 1ps
module pcx_rle_line_decoder_core_test;
  import pcxrle_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettlePause = 100;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned HoldCycles  = 400;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_req_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_res_t             out_data_o;

  // size registers as the block holds them
  int unsigned width_reg = 1;
  int unsigned height_reg = 1;
  int unsigned stride_reg = 1;

  // decoder state
  bit          awaiting = 1'b0;
  logic [5:0]  held_count = '0;
  int unsigned cur_col = 0;
  int unsigned cur_line = 0;
  bit          halted = 1'b0;

  out_res_t decoded_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned noise_pct = 0;
  int unsigned item_goal = 0;
  int unsigned hold_cycles_req = 0;
  int unsigned hold_trigger = 0;

  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_results = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;

  pcx_rle_line_decoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > 65536) return 65536;
    return v;
  endfunction

  function automatic void flag_error(status_e code);
    out_res_t r;
    r = '0;
    r.status = code;
    r.run_end = 1'b1;
    decoded_q.push_back(r);
    halted = 1'b1;
    awaiting = 1'b0;
    held_count = '0;
  endfunction

  function automatic void decode_byte(in_req_t req);
    int unsigned     w, h, s, cnt, k;
    longint unsigned room;
    out_res_t        held;
    bit              have;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    s = stride_reg;
    have = 1'b0;
    held = '0;
    if (req.first_byte) begin
      awaiting = 1'b0;
      held_count = '0;
      cur_col = 0;
      cur_line = 0;
      halted = 1'b0;
    end
    if (halted) return;
    if (s < w) begin
      flag_error(STATUS_BAD_STRIDE);
      return;
    end
    if (awaiting) begin
      cnt = 32'(held_count);
      awaiting = 1'b0;
      held_count = '0;
    end else if ((req.data_byte & RunMark) == RunMark) begin
      cnt = 32'(req.data_byte & RunMask);
      if (cnt == 0) begin
        flag_error(STATUS_ZERO_RUN);
        return;
      end
      if (req.final_byte) begin
        flag_error(STATUS_RUN_CUT);
        return;
      end
      awaiting = 1'b1;
      held_count = cnt[5:0];
      return;
    end else begin
      cnt = 1;
    end
    // a position outside the current sizes leaves no room at all
    if (cur_line < h && cur_col < s)
      room = 64'(h - 1 - cur_line) * 64'(s) + 64'(s - cur_col);
    else
      room = 0;
    if (cnt > room) begin
      flag_error(STATUS_OVERRUN);
      return;
    end
    if (req.final_byte && cnt != room) begin
      flag_error(STATUS_DATA_ENDED);
      return;
    end
    for (k = 0; k < cnt; k++) begin
      if (cur_col < w) begin
        if (have) decoded_q.push_back(held);
        held = '0;
        held.status = STATUS_PIXEL;
        held.pixel = req.data_byte;
        held.column = cur_col[15:0];
        held.line = cur_line[15:0];
        held.image_done = (cur_col == w - 1) && (cur_line == h - 1);
        have = 1'b1;
      end
      cur_col++;
      if (cur_col >= s) begin
        cur_col = 0;
        cur_line = (cur_line + 1) & 32'h1ffff;
      end
    end
    if (have) begin
      held.run_end = 1'b1;
      decoded_q.push_back(held);
    end
    if (cnt == room) halted = 1'b1;
    cur_line &= 32'hffff;
  endfunction

  task automatic check_result(out_res_t got);
    out_res_t want;
    results_seen++;
    if (got.status != STATUS_PIXEL) error_results++;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("unexpected result: status %0d pixel %02h col %0d line %0d",
                 got.status, got.pixel, got.column, got.line);
      return;
    end
    want = decoded_q.pop_front();
    if (got.status !== want.status || got.pixel !== want.pixel ||
        got.column !== want.column || got.line !== want.line ||
        got.run_end !== want.run_end || got.image_done !== want.image_done) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display({"result %0d: expected st %0d px %02h col %0d line %0d end %0b done %0b,",
                  " got st %0d px %02h col %0d line %0d end %0b done %0b"},
                 results_seen, want.status, want.pixel, want.column, want.line,
                 want.run_end, want.image_done, got.status, got.pixel, got.column,
                 got.line, got.run_end, got.image_done);
    end
  endtask

  initial begin : result_side
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) check_result(out_data_o);
      if (hold_served != hold_trigger) begin
        hold_served = hold_trigger;
        hold_left = hold_cycles_req;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] data, bit is_first, bit is_final);
    in_req_t req;
    if ($urandom_range(99) < noise_pct) begin
      data = 8'($urandom);
      is_first = ($urandom_range(7) == 0);
      is_final = ($urandom_range(7) == 0);
    end
    req.data_byte = data;
    req.first_byte = is_first;
    req.final_byte = is_final;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    decode_byte(req);
    requests_sent++;
  endtask

  // padding-only requests may still be expanding once the queue is empty
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettlePause) @(posedge clk_i);
  endtask

  task automatic write_size(logic [1:0] idx, int unsigned value);
    wait_quiet();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWidth:  width_reg = value & 32'h1ffff;
      RegHeight: height_reg = value & 32'h1ffff;
      RegStride: stride_reg = value & 32'hffff;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned s);
    write_size(RegWidth, w);
    write_size(RegHeight, h);
    write_size(RegStride, s);
    settings_used++;
  endtask

  // encodes one image of the current size as runs and literals, stopping early at the item goal
  task automatic send_image(int unsigned pct);
    longint unsigned left;
    int unsigned     n, lim;
    logic [7:0]      v;
    bit              first;
    noise_pct = pct;
    left = 64'(clamp_dim(height_reg)) * 64'(stride_reg);
    first = 1'b1;
    while (left != 0 && requests_sent < item_goal) begin
      lim = (left > 63) ? 63 : 32'(left);
      if ($urandom_range(3) == 0) n = $urandom_range(1, lim);
      else n = $urandom_range(1, (lim < 6) ? lim : 6);
      v = 8'($urandom);
      if (n == 1 && v < RunMark && $urandom_range(1) == 1) begin
        left -= 1;
        send_byte(v, first, left == 0);
      end else begin
        send_byte({2'b11, 6'(n)}, first, 1'b0);
        left -= n;
        send_byte(v, 1'b0, left == 0);
      end
      first = 1'b0;
    end
    noise_pct = 0;
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned items);
    int unsigned w;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    item_goal = requests_sent + items;
    while (requests_sent < item_goal) begin
      w = ($urandom_range(5) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 10);
      set_geometry(w, $urandom_range(1, 4),
                   ($urandom_range(9) == 0) ? w - 1 : w + $urandom_range(0, 3));
      repeat ($urandom_range(1, 3)) send_image(($urandom_range(3) == 0) ? 15 : 0);
    end
    wait_quiet();
  endtask

  task automatic test_reset_size();
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h42, 1'b0, 1'b0);
  endtask

  task automatic test_run_expansion();
    set_geometry(4, 2, 6);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hc3, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hbf, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hcc, 1'b1, 1'b0);
    send_byte(8'haa, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);
  endtask

  task automatic test_error_codes();
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hc0, 1'b1, 1'b0);
    send_byte(8'hc5, 1'b1, 1'b1);
    send_byte(8'h7f, 1'b1, 1'b1);
    send_byte(8'hc0, 1'b1, 1'b1);
  endtask

  task automatic test_size_limits();
    set_geometry(0, 32'h1ffff, 65535);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'hc1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    write_size(RegWidth, 65536);
    send_byte(8'h3c, 1'b1, 1'b0);
    set_geometry(1, 1, 0);
    send_byte(8'h01, 1'b1, 1'b0);
    wait_quiet();
  endtask

  task automatic test_backpressure();
    int unsigned k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_geometry(8, 8, 8);
    hold_cycles_req = HoldCycles;
    hold_trigger++;
    for (k = 0; k < 8; k++) begin
      send_byte(8'hc8, k == 0, 1'b0);
      send_byte(8'($urandom), 1'b0, k == 7);
    end
    wait_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_run_expansion();
    test_error_codes();
    test_size_limits();
    test_backpressure();
    run_phase(0, 0, 48);
    run_phase(60, 0, 48);
    run_phase(0, 60, 48);
    run_phase(26, 26, 48);
    wait_quiet();
    $display("%0d requests decoded under %0d size settings, %0d results checked (%0d errors)",
             requests_sent, settings_used, results_seen, error_results);
    $display("flow: free, sender gaps, receiver stalls, both, plus a %0d-cycle output hold",
             HoldCycles);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
